// File: rtl/crc_pkg.sv
package crc_pkg;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_READ,
    ST_AGC,
    ST_VD,
    ST_CV,
    ST_RD,
    ST_AZ1,
    ST_CZ2,
    ST_CZ1,
    ST_AZ2,
    ST_Z1R,
    ST_Z2R,
    ST_VEL,
    ST_X,
    ST_T2,
    ST_T4,
    ST_HZ,
    ST_Y,
    ST_EMIT
  } state_t;

  // operations of the shared unit
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_VEL
  } alu_op_t;

  // word select codes
  localparam logic [2:0] SEL_R    = 3'd0;
  localparam logic [2:0] SEL_A    = 3'd1;
  localparam logic [2:0] SEL_C    = 3'd2;
  localparam logic [2:0] SEL_H    = 3'd3;
  localparam logic [2:0] SEL_G    = 3'd4;
  localparam logic [2:0] SEL_DINC = 3'd5;

  localparam int NWORDS = 5;

  // configuration register indexes
  localparam logic CFG_CHANNELS = 1'b0;
  localparam logic CFG_VGAIN    = 1'b1;

  localparam logic [6:0]  CHANNELS_RESET = 7'd64;
  localparam logic [23:0] VGAIN_RESET    = 24'd33554;

endpackage

// File: rtl/crc_ram.sv
module crc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/crc_alu.sv
module crc_alu
  import crc_pkg::*;
#(
  parameter int DW = 24
) (
  input  alu_op_t              op,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  input  logic        [23:0]   gain,
  output logic signed [DW-1:0] res
);

  localparam int FRAC = DW - 2;
  localparam int PW = 2 * DW + 2;

  logic signed [PW-1:0] wide;
  logic signed [PW-1:0] shifted;
  logic signed [DW:0]   diff;
  logic signed [PW-1:0] qmax;
  logic signed [PW-1:0] qmin;

  assign qmax = PW'((65'sd1 <<< (DW - 1)) - 65'sd1);
  assign qmin = -PW'(65'sd1 <<< (DW - 1));
  assign diff = (DW+1)'(a) - (DW+1)'(b);

  // one add, subtract, rounded multiply or rounded velocity product (difference times gain), then saturation
  always_comb begin
    wide = '0;
    shifted = '0;
    unique case (op)
      OP_ADD: shifted = PW'(a) + PW'(b);
      OP_SUB: shifted = PW'(a) - PW'(b);
      OP_MUL: begin
        wide = PW'(a) * PW'(b);
        shifted = (wide + (PW'(1) <<< (FRAC - 1))) >>> FRAC;
      end
      OP_VEL: begin
        wide = PW'(diff) * PW'($signed({1'b0, gain}));
        shifted = (wide + (PW'(1) <<< 23)) >>> 24;
      end
      default: shifted = '0;
    endcase
    if (shifted > qmax) begin
      res = DW'(qmax);
    end else if (shifted < qmin) begin
      res = DW'(qmin);
    end else begin
      res = DW'(shifted);
    end
  end

endmodule

// File: rtl/cochlear_resonator_cascade_step.sv
// Cascade of asymmetric resonators, stepped once per audio sample.
// Input channel (in_valid/in_stall): action 1 loads one per-channel word
// (r, a, c, h, g or damping increment) and yields no result; action 0
// runs one step over channels 0 .. channels_in_use-1, channels_in_use
// clamped to 1 .. NUM_CHANNELS, stage 0 fed the sample and each later
// stage fed its neighbour's output of the last step. One result transfer
// per channel leaves on out_valid/out_stall, with last set on the final
// channel. A load does not stall the input, and loads may follow back to
// back. Per channel, a sample runs one registered read of the channel's
// coefficient and state memories, 22 operations through one shared
// multiply/add unit with saturation, and the hand-over of the result.
// A sample keeps the input stalled until its last channel result is
// handed over, so no further transfer is taken before then.
// When the receiver stalls, the next channel runs up to its result and
// waits there until the held result is taken.
// Reset (rst_n low, synchronous) sets channels_in_use to 64, velocity
// gain to 33554 and empties the filter state through valid bits; the
// coefficient table stays undefined until loaded. Configuration writes
// (cfg_valid/cfg_ready) are taken at any time, but belong to idle periods.
module cochlear_resonator_cascade_step
  import crc_pkg::*;
#(
  parameter int NUM_CHANNELS = 64,
  parameter int DATA_WIDTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [23:0] in_sample,
  input  logic [5:0]  in_channel,
  input  logic [2:0]  in_word_select,
  input  logic [23:0] in_word_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_channel,
  output logic [23:0] out_stage_output,
  output logic [22:0] out_detect,
  output logic [31:0] out_detect_total,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNW = $clog2(NUM_CHANNELS + 1);
  localparam int NST = 7;

  typedef logic signed [DW-1:0] data_t;

  // saturate a 24 bit loaded value to the data width
  function automatic data_t sat_in(input logic [23:0] v);
    logic signed [33:0] s;
    logic signed [33:0] mx;
    begin
      s = 34'(signed'(v));
      mx = (34'sd1 <<< (DW - 1)) - 34'sd1;
      if (s > mx) sat_in = DW'(mx);
      else if (s < -mx - 34'sd1) sat_in = DW'(-mx - 34'sd1);
      else sat_in = DW'(s);
    end
  endfunction

  state_t state_r, state_nxt;
  logic [6:0]  chans_r;
  logic [23:0] vgain_r;
  logic [CW-1:0] ch_r, ch_nxt;
  logic [CNW-1:0] n_run;
  data_t feed_r, feed_nxt;
  logic [NUM_CHANNELS-1:0] st_valid_r;

  // working registers
  data_t cr_r, ca_r, cc_r, ch_h_r, cg_r;
  data_t z1_r, z2_r, vd_r, agc_r, dinc_r, prev_r;
  logic [31:0] dsum_r;
  data_t t1_r, t2_r, rd_r, z1n_r, z2n_r;
  data_t out_y_r;
  logic [31:0] out_tot_r;
  logic out_last_r, out_valid_r;
  logic [CW-1:0] out_ch_r;

  // coefficient memory, one per word
  logic [NWORDS-1:0] cwe;
  data_t crd [NWORDS];
  logic load_acc;
  assign in_stall = (state_r != ST_IDLE);
  assign load_acc = in_valid && !in_stall && in_action
                 && (32'(in_channel) < NUM_CHANNELS);

  // memories are addressed with the channel about to be read
  for (genvar w = 0; w < NWORDS; w++) begin : g_coef
    assign cwe[w] = load_acc && (in_word_select == 3'(w));
    crc_ram #(.WIDTH(DW), .DEPTH(NUM_CHANNELS)) u_coef (
      .clk(clk), .we(cwe[w]), .waddr(CW'(in_channel)),
      .wdata(sat_in(in_word_value)), .raddr(ch_nxt), .rdata(crd[w]));
  end

  // per-channel state memories: dinc, z1, z2, vd, agc, prev, dsum
  logic st_we;
  logic [NST-2:0] swe;
  logic [CW-1:0] swaddr;
  data_t swd [NST-1];
  data_t srd [NST-1];
  logic [31:0] dsum_rd, dsum_wd;
  logic dinc_we;

  assign dinc_we = load_acc && (in_word_select == SEL_DINC);
  assign swe[0] = dinc_we;
  for (genvar k = 1; k < NST - 1; k++) begin : g_swe
    assign swe[k] = st_we;
  end
  assign swaddr = dinc_we ? CW'(in_channel) : ch_r;
  assign swd[0] = sat_in(in_word_value);
  assign swd[1] = z1n_r;
  assign swd[2] = z2n_r;
  assign swd[3] = vd_r;
  assign swd[4] = agc_r;
  assign swd[5] = out_y_r;
  assign dsum_wd = out_tot_r;

  for (genvar k = 0; k < NST - 1; k++) begin : g_st
    crc_ram #(.WIDTH(DW), .DEPTH(NUM_CHANNELS)) u_st (
      .clk(clk), .we(swe[k]), .waddr(swaddr), .wdata(swd[k]),
      .raddr(ch_nxt), .rdata(srd[k]));
  end
  crc_ram #(.WIDTH(32), .DEPTH(NUM_CHANNELS)) u_dsum (
    .clk(clk), .we(st_we), .waddr(ch_r), .wdata(dsum_wd),
    .raddr(ch_nxt), .rdata(dsum_rd));

  // damping increment has its own valid bits
  logic [NUM_CHANNELS-1:0] dinc_valid_r;

  // shared unit
  alu_op_t op;
  data_t opa, opb, res;
  crc_alu #(.DW(DW)) u_alu (.op(op), .a(opa), .b(opb), .gain(vgain_r), .res(res));

  localparam data_t QONE = data_t'(1) <<< (DW - 2);

  assign n_run = (chans_r == 7'd0) ? CNW'(1)
               : (32'(chans_r) > NUM_CHANNELS) ? CNW'(NUM_CHANNELS) : CNW'(chans_r);

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r <= CHANNELS_RESET;
      vgain_r <= VGAIN_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHANNELS: chans_r <= cfg_data[6:0];
        CFG_VGAIN:    vgain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // tail of velocity and output chain, stepped by a small sub-counter
  // while in ST_EMIT, on the same shared unit
  logic [2:0] tail_r;
  alu_op_t top;
  data_t ta, tb;
  logic tail_busy;
  assign tail_busy = (state_r == ST_EMIT) && (tail_r != 3'd6);
  always_comb begin
    top = OP_MUL; ta = '0; tb = '0;
    unique case (tail_r)
      3'd0: begin top = OP_MUL; ta = t1_r; tb = t1_r; end
      3'd1: begin top = OP_MUL; ta = t1_r; tb = t1_r; end
      3'd2: begin top = OP_SUB; ta = QONE; tb = t1_r; end
      3'd3: begin top = OP_MUL; ta = ch_h_r; tb = z2n_r; end
      3'd4: begin top = OP_ADD; ta = feed_r; tb = t2_r; end
      3'd5: begin top = OP_MUL; ta = cg_r; tb = t2_r; end
      default: begin top = OP_ADD; ta = '0; tb = '0; end
    endcase
  end

  // sequencer and shared unit operand selection
  always_comb begin
    state_nxt = state_r;
    ch_nxt = ch_r;
    feed_nxt = feed_r;
    op = OP_ADD;
    opa = '0;
    opb = '0;
    st_we = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_action) begin
          state_nxt = ST_READ;
          ch_nxt = '0;
        end
      end
      ST_READ: state_nxt = ST_AGC;
      ST_AGC: begin op = OP_ADD; opa = agc_r; opb = dinc_r; state_nxt = ST_VD; end
      ST_VD:  begin op = OP_ADD; opa = vd_r; opb = agc_r; state_nxt = ST_CV; end
      ST_CV:  begin op = OP_MUL; opa = cc_r; opb = t1_r; state_nxt = ST_RD; end
      ST_RD:  begin op = OP_SUB; opa = cr_r; opb = t1_r; state_nxt = ST_AZ1; end
      ST_AZ1: begin op = OP_MUL; opa = ca_r; opb = z1_r; state_nxt = ST_CZ2; end
      ST_CZ2: begin op = OP_MUL; opa = cc_r; opb = z2_r; state_nxt = ST_CZ1; end
      ST_CZ1: begin op = OP_SUB; opa = t1_r; opb = t2_r; state_nxt = ST_AZ2; end
      ST_AZ2: begin op = OP_MUL; opa = rd_r; opb = t1_r; state_nxt = ST_Z1R; end
      ST_Z1R: begin op = OP_ADD; opa = t1_r; opb = feed_r; state_nxt = ST_Z2R; end
      ST_Z2R: begin op = OP_MUL; opa = cc_r; opb = z1_r; state_nxt = ST_VEL; end
      ST_VEL: begin op = OP_MUL; opa = ca_r; opb = z2_r; state_nxt = ST_X; end
      ST_X:   begin op = OP_ADD; opa = t1_r; opb = t2_r; state_nxt = ST_T2; end
      ST_T2:  begin op = OP_MUL; opa = rd_r; opb = t1_r; state_nxt = ST_T4; end
      ST_T4:  begin op = OP_VEL; opa = z2n_r; opb = z2_r; state_nxt = ST_HZ; end
      ST_HZ:  begin op = OP_MUL; opa = t1_r; opb = t1_r; state_nxt = ST_Y; end
      ST_Y:   begin op = OP_SUB; opa = QONE; opb = t1_r; state_nxt = ST_EMIT; end
      ST_EMIT: begin
        op = top;
        opa = ta;
        opb = tb;
        if (!out_valid_r || !out_stall) begin
          st_we = 1'b1;
          feed_nxt = prev_r;
          if (32'(ch_r) + 1 >= 32'(n_run)) begin
            state_nxt = ST_IDLE;
          end else begin
            ch_nxt = ch_r + CW'(1);
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic emit_go;
  assign emit_go = (state_r == ST_EMIT) && !tail_busy && (!out_valid_r || !out_stall);

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r <= '0;
      st_valid_r <= '0;
      dinc_valid_r <= '0;
      out_valid_r <= 1'b0;
      tail_r <= 3'd0;
    end else begin
      if (state_r != ST_EMIT || emit_go) begin
        state_r <= state_nxt;
        ch_r <= ch_nxt;
      end
      if (dinc_we) dinc_valid_r[in_channel[CW-1:0]] <= 1'b1;
      if (emit_go) st_valid_r[ch_r] <= 1'b1;
      if (emit_go) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_EMIT) begin
        if (tail_busy) tail_r <= tail_r + 3'd1;
      end else begin
        tail_r <= 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid && !in_action) begin
      feed_r <= sat_in(in_sample);
    end else if (emit_go) begin
      feed_r <= feed_nxt;
    end
    unique case (state_r)
      ST_READ: begin
        cr_r <= crd[0]; ca_r <= crd[1]; cc_r <= crd[2];
        ch_h_r <= crd[3]; cg_r <= crd[4];
        dinc_r <= dinc_valid_r[ch_r] ? srd[0] : '0;
        z1_r   <= st_valid_r[ch_r] ? srd[1] : '0;
        z2_r   <= st_valid_r[ch_r] ? srd[2] : '0;
        vd_r   <= st_valid_r[ch_r] ? srd[3] : '0;
        agc_r  <= st_valid_r[ch_r] ? srd[4] : '0;
        prev_r <= st_valid_r[ch_r] ? srd[5] : '0;
        dsum_r <= st_valid_r[ch_r] ? dsum_rd : '0;
      end
      ST_AGC: agc_r <= res;
      ST_VD:  t1_r <= res;
      ST_CV:  t1_r <= res;
      ST_RD:  rd_r <= res;
      ST_AZ1: t1_r <= res;
      ST_CZ2: t2_r <= res;
      ST_CZ1: t1_r <= res;
      ST_AZ2: t1_r <= res;
      ST_Z1R: z1n_r <= res;
      ST_Z2R: t1_r <= res;
      ST_VEL: t2_r <= res;
      ST_X:   t1_r <= res;
      ST_T2:  z2n_r <= res;
      ST_T4:  t1_r <= res;
      ST_HZ:  t1_r <= res;
      ST_Y:   t1_r <= res;
      ST_EMIT: begin
        unique case (tail_r)
          3'd0: t1_r <= res;
          3'd1: t1_r <= res;
          3'd2: vd_r <= res >>> 2;
          3'd3: t2_r <= res;
          3'd4: t2_r <= res;
          3'd5: begin
            out_y_r <= res;
            out_tot_r <= ((33'(dsum_r) + 33'(res > 0 ? res : '0)) > 33'hFFFF_FFFF)
                       ? 32'hFFFF_FFFF
                       : 32'(33'(dsum_r) + 33'(res > 0 ? res : '0));
          end
          default: ;
        endcase
        if (emit_go) begin
          out_ch_r <= ch_r;
          out_last_r <= (32'(ch_r) + 1 >= 32'(n_run));
        end
      end
      default: ;
    endcase
  end

  // output register holds the last channel result until taken
  data_t oy_r;
  logic [31:0] otot_r;
  always_ff @(posedge clk) begin
    if (emit_go) begin
      oy_r <= out_y_r;
      otot_r <= out_tot_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_channel = 6'(out_ch_r);
  assign out_stage_output = 24'(oy_r);
  assign out_detect = (oy_r > 0) ? 23'(oy_r) : 23'd0;
  assign out_detect_total = otot_r;
  assign out_last = out_last_r;

endmodule

// File: dv/cochlear_resonator_cascade_step_tb.sv
`timescale 1ns / 100ps

module cochlear_resonator_cascade_step_tb;
  import crc_pkg::*;

  localparam int  NCH = 64;
  localparam longint QMAX = 64'sd8388607;
  localparam longint QMIN = -64'sd8388608;
  localparam longint QONE = 64'sd4194304;
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_LOAD   = 1'b1;
  localparam int  IDLE_PCT = 27;

  typedef struct packed {
    logic        action;
    logic [23:0] sample;
    logic [5:0]  channel;
    logic [2:0]  word_select;
    logic [23:0] word_value;
  } item_t;

  typedef struct packed {
    logic [5:0]  channel;
    logic [23:0] stage_output;
    logic [22:0] detect;
    logic [31:0] detect_total;
    logic        last;
  } tap_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [23:0] in_sample = '0;
  logic [5:0]  in_channel = '0;
  logic [2:0]  in_word_select = '0;
  logic [23:0] in_word_value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_channel;
  logic [23:0] out_stage_output;
  logic [22:0] out_detect;
  logic [31:0] out_detect_total;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [23:0] cfg_data = '0;

  cochlear_resonator_cascade_step DUT (.*);

  always #5 clk = ~clk;

  // stimulus and expected taps
  item_t  pending[$];
  tap_t   expected_taps[$];
  item_t  cur;
  bit     calm = 1'b0;
  int     fails = 0;
  int     samples_run = 0;
  int     loads_done = 0;
  int     taps_seen = 0;

  // shadow of the cascade
  longint coef[NWORDS][NCH];
  longint dinc[NCH], z1s[NCH], z2s[NCH], vdamp[NCH], agc[NCH], prev_y[NCH];
  longint unsigned dsum[NCH];
  longint chans_cfg = 64;
  longint vgain_cfg = 33554;

  function automatic longint qsat(input longint v);
    if (v > QMAX) return QMAX;
    if (v < QMIN) return QMIN;
    return v;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return qsat((a * b + (64'sd1 <<< 21)) >>> 22);
  endfunction

  // append an item to the stimulus queue
  function automatic void add_item(input item_t it);
    pending.insert(pending.size(), it);
  endfunction

  // advance the cascade by one transfer, queueing the taps it produces
  function automatic void step_cascade(input item_t it);
    longint feed[NCH];
    longint r, a, c, h, g, z1, z2, rd, z1n, z2n, v, x, t, t4, y, det;
    longint unsigned acc;
    int n;
    tap_t e;
    if (it.action == ACT_LOAD) begin
      if (it.word_select < SEL_DINC)
        coef[it.word_select][it.channel] = longint'($signed(it.word_value));
      else if (it.word_select == SEL_DINC)
        dinc[it.channel] = longint'($signed(it.word_value));
      return;
    end
    n = (chans_cfg < 1) ? 1 : (chans_cfg > NCH) ? NCH : int'(chans_cfg);
    feed[0] = longint'($signed(it.sample));
    for (int i = 1; i < NCH; i++) feed[i] = prev_y[i-1];
    for (int i = 0; i < n; i++) begin
      r = coef[SEL_R][i]; a = coef[SEL_A][i]; c = coef[SEL_C][i];
      h = coef[SEL_H][i]; g = coef[SEL_G][i];
      z1 = z1s[i]; z2 = z2s[i];
      agc[i] = qsat(agc[i] + dinc[i]);
      rd = qsat(r - qmul(c, qsat(vdamp[i] + agc[i])));
      z1n = qsat(qmul(rd, qsat(qmul(a, z1) - qmul(c, z2))) + feed[i]);
      z2n = qmul(rd, qsat(qmul(c, z1) + qmul(a, z2)));
      z1s[i] = z1n;
      z2s[i] = z2n;
      // velocity nonlinearity: damping from 1 - (1 - v*v)^4, scaled by a quarter
      v = qsat(((z2n - z2) * vgain_cfg + (64'sd1 <<< 23)) >>> 24);
      x = qmul(v, v);
      t = qsat(QONE - x);
      t = qmul(t, t);
      t4 = qmul(t, t);
      vdamp[i] = qsat(QONE - t4) >>> 2;
      y = qmul(g, qsat(feed[i] + qmul(h, z2n)));
      prev_y[i] = y;
      det = (y > 0) ? y : 0;
      acc = dsum[i] + longint'(det);
      if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
      dsum[i] = acc;
      e.channel = i[5:0];
      e.stage_output = y[23:0];
      e.detect = det[22:0];
      e.detect_total = acc[31:0];
      e.last = (i == n - 1);
      expected_taps.insert(expected_taps.size(), e);
    end
  endfunction

  // driver: one item per transfer, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        step_cascade(cur);
        if (cur.action == ACT_LOAD) loads_done++;
        else samples_run++;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur = pending.pop_front();
          in_action <= cur.action;
          in_sample <= cur.sample;
          in_channel <= cur.channel;
          in_word_select <= cur.word_select;
          in_word_value <= cur.word_value;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    tap_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        taps_seen++;
        if (expected_taps.size() == 0) begin
          $error("unexpected result: channel %0d", out_channel);
          fails++;
        end else begin
          e = expected_taps.pop_front();
          if (out_channel !== e.channel) begin
            $error("out_channel: expected %0d, got %0d", e.channel, out_channel);
            fails++;
          end
          if (out_stage_output !== e.stage_output) begin
            $error("stage_output: expected %h, got %h", e.stage_output, out_stage_output);
            fails++;
          end
          if (out_detect !== e.detect) begin
            $error("detect: expected %h, got %h", e.detect, out_detect);
            fails++;
          end
          if (out_detect_total !== e.detect_total) begin
            $error("detect_total: expected %h, got %h", e.detect_total, out_detect_total);
            fails++;
          end
          if (out_last !== e.last) begin
            $error("last: expected %0d, got %0d", e.last, out_last);
            fails++;
          end
        end
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic item_t make_load(input int ch, input logic [2:0] sel,
                                      input logic [23:0] val);
    item_t it;
    it.action = ACT_LOAD;
    it.sample = 24'($urandom);
    it.channel = ch[5:0];
    it.word_select = sel;
    it.word_value = val;
    return it;
  endfunction

  function automatic item_t make_sample(input logic [23:0] s);
    item_t it;
    it.action = ACT_SAMPLE;
    it.sample = s;
    it.channel = 6'($urandom);
    it.word_select = 3'($urandom);
    it.word_value = 24'($urandom);
    return it;
  endfunction

  // plausible resonator word for the given select
  function automatic logic [23:0] sane_word(input logic [2:0] sel);
    case (sel)
      SEL_R:   return 24'($urandom_range(4190000, 3800000));
      SEL_A:   return 24'($urandom_range(4194304, 2000000));
      SEL_C:   return 24'($urandom_range(1500000, 0));
      SEL_H:   return 24'(int'($urandom_range(800000, 0)) - 400000);
      SEL_G:   return 24'($urandom_range(4600000, 3000000));
      default: return 24'(int'($urandom_range(2000, 0)) - 1000);
    endcase
  endfunction

  function automatic item_t rand_item();
    int k;
    logic [2:0] sel;
    k = $urandom_range(99);
    if (k < 75) begin
      if ($urandom_range(3) == 0) return make_sample(24'($urandom));
      return make_sample(24'(int'($urandom_range(800000, 0)) - 400000));
    end
    if (k < 78) return make_load($urandom_range(63), 3'($urandom_range(7, 6)), 24'($urandom));
    sel = 3'($urandom_range(5));
    if (k < 84) return make_load($urandom_range(63), sel, 24'($urandom));
    return make_load($urandom_range(63), sel, sane_word(sel));
  endfunction

  task automatic wait_idle();
    do @(posedge clk);
    while (pending.size() != 0 || in_valid || expected_taps.size() != 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [23:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CHANNELS) chans_cfg = longint'(val[6:0]);
    else vgain_cfg = longint'(val);
  endtask

  // stimulus sequence
  initial begin
    int        counts[6] = '{0, 1, 127, 8, 3, 16};
    int        lens[6]   = '{15, 15, 10, 20, 17, 17};
    logic [23:0] gains[6];
    for (int s = 0; s < NWORDS; s++)
      for (int i = 0; i < NCH; i++) coef[s][i] = 0;
    for (int i = 0; i < NCH; i++) begin
      dinc[i] = 0; z1s[i] = 0; z2s[i] = 0; vdamp[i] = 0;
      agc[i] = 0; prev_y[i] = 0; dsum[i] = 0;
    end
    gains = '{24'd0, 24'hFFFFFF, 24'd33554, 24'($urandom), 24'($urandom), 24'($urandom)};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // fill the whole coefficient table before any sample
    for (int i = 0; i < NCH; i++)
      for (int s = 0; s < NWORDS; s++)
        add_item(make_load(i, 3'(s), sane_word(3'(s))));
    wait_idle();

    // directed: sample extremes, ignored selects, load value extremes
    add_item(make_sample(24'h7FFFFF));
    add_item(make_sample(24'h800000));
    add_item(make_sample(24'h000000));
    add_item(make_sample(24'hFFFFFF));
    add_item(make_load(5, 3'd6, 24'h7FFFFF));
    add_item(make_load(63, 3'd7, 24'h800000));
    add_item(make_sample(24'h000001));
    add_item(make_load(63, SEL_H, 24'h7FFFFF));
    add_item(make_load(62, SEL_G, 24'h800000));
    add_item(make_load(0, SEL_DINC, 24'h7FFFFF));
    add_item(make_sample(24'h7FFFFF));
    add_item(make_sample(24'h800000));
    add_item(make_load(0, SEL_DINC, 24'h000000));
    add_item(make_load(63, SEL_H, sane_word(SEL_H)));
    add_item(make_load(62, SEL_G, sane_word(SEL_G)));
    add_item(make_sample(24'h400000));
    wait_idle();

    // random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      write_cfg(CFG_CHANNELS, 24'(counts[p]));
      write_cfg(CFG_VGAIN, gains[p]);
      calm = (p == 3);
      for (int k = 0; k < lens[p]; k++) add_item(rand_item());
      wait_idle();
    end
    calm = 1'b0;

    $display("run covered %0d samples and %0d word loads, %0d results checked",
             samples_run, loads_done, taps_seen);
    $display("channel counts 0, 1, 8, 3, 16, 64 and 127 with velocity gains from 0 to full");
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
